### src/f2da_pkg.sv
// ============================================================================
// f2da_pkg: shared types and constants for the float-to-decimal text block
// Character codes, status codes, register map and the BCD unit interface.
// ============================================================================
package f2da_pkg;

  // configuration port geometry
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int BUF_W   = 7;

  // register index of buffer_size (paddr bit 2 selects the register)
  localparam logic REG_BUF_SIZE = 1'b0;
  localparam logic [BUF_W-1:0] BUF_SIZE_RST = 7'd8;

  // integer part: below 2^31, so 31 bits and ten decimal digits
  localparam int IBITS  = 31;
  localparam int NDIG   = 10;
  localparam int BCD_W  = 4 * NDIG;
  localparam int ICNT_W = 5;
  localparam int DCNT_W = 4;

  // exponent field limits
  localparam logic [7:0] EXPO_OOR   = 8'd158;
  localparam logic [7:0] SHIFT_BIAS = 8'd157;
  localparam logic [7:0] SHIFT_SUB  = 8'd156;

  // ASCII
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // control into the serial binary-to-BCD unit
  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctl_t;

  // status back from it
  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } bcd_sts_t;

endpackage

### src/f2da_bcd.sv
// ============================================================================
// f2da_bcd: serial binary-to-BCD converter
// Shift-and-add-3 over the integer part, one bit per cycle, then hands the
// decimal digits out most significant first on request.
// ============================================================================
module f2da_bcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  f2da_pkg::bcd_ctl_t        ctl,
  input  logic [f2da_pkg::IBITS-1:0] bin,
  output f2da_pkg::bcd_sts_t        sts
);
  import f2da_pkg::*;

  logic [IBITS-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [ICNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [BCD_W-1:0]  adj;

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
  end

  // load, convert one bit a cycle, or pop the top digit
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.load) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = ICNT_W'(IBITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt  = {adj[BCD_W-2:0], bin_r[IBITS-1]};
      bin_nxt  = {bin_r[IBITS-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != ICNT_W'(1));
    end else if (ctl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.done  = !busy_r;
  assign sts.digit = bcd_r[BCD_W-1 -: 4];

endmodule

### src/float_to_decimal_ascii.sv
// ============================================================================
// float_to_decimal_ascii: single-precision float to decimal ASCII text
// Serial converter: aligns the value to fixed point, turns the integer part
// into decimal and streams the text out one character per request.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_float_bits) takes one raw IEEE
//   single-precision pattern per request. in_stall stays high from accept
//   until the last character of that value has been loaded into the output
//   register; one value is converted at a time.
//   Output channel (out_valid / out_stall / out_text_char / out_last_char /
//   out_status) gives one character per request; out_last_char marks the
//   final one. Error and empty-buffer cases give one request with a NUL char.
//   APB port: register 0 (buffer_size, reset 8) at address 0; the user must write it
//   only while the block is idle, which the block itself does not enforce. pready is tied high.
// Sequence: a decode state, then the alignment shifter moves 8 or 1 bits a
//   cycle, then the BCD unit converts the 31-bit integer part, then leading
//   zero digits are skipped and the characters are emitted. Null-buffer,
//   one-byte-buffer and out-of-range values answer straight from the decode
//   state. Back-pressure on out_stall simply holds the sequencer.
// Reset: synchronous, active low; clears control and sets buffer_size to 8.
// ============================================================================
module float_to_decimal_ascii #(
  parameter int MAX_BUFFER = 64,
  parameter int FRAC_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_float_bits,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_text_char,
  output logic                          out_last_char,
  output logic [1:0]                    out_status,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [f2da_pkg::PADDR_W-1:0]  paddr,
  input  logic [f2da_pkg::PDATA_W-1:0]  pwdata,
  output logic [f2da_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import f2da_pkg::*;

  localparam int CW = (MAX_BUFFER > 2) ? $clog2(MAX_BUFFER) : 1;
  localparam int XW = IBITS + FRAC_BITS;
  localparam logic [BUF_W-1:0] MAXB = BUF_W'(MAX_BUFFER);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ALIGN  = 3'd2;
  localparam logic [2:0] S_BCD    = 3'd3;
  localparam logic [2:0] S_SIGN   = 3'd4;
  localparam logic [2:0] S_INT    = 3'd5;
  localparam logic [2:0] S_DOT    = 3'd6;
  localparam logic [2:0] S_FRAC   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [BUF_W-1:0]    buf_size_r;
  logic [31:0]         bits_r, bits_nxt;
  logic [XW-1:0]       x_r, x_nxt;
  logic [7:0]          sh_r, sh_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       limit_r, limit_nxt;
  logic [DCNT_W-1:0]   dig_r, dig_nxt;
  logic                lead_r, lead_nxt;
  logic                neg_r, neg_nxt;
  logic                int_nz_r, int_nz_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                out_free;
  logic                emit;
  logic                at_limit;
  logic [BUF_W-1:0]    size_clip;
  logic [7:0]          expo;
  logic [23:0]         mant24;
  logic                frac_zero;
  logic [FRAC_BITS+3:0] prod;
  logic                cfg_wr;
  bcd_ctl_t            bcd_ctl;
  bcd_sts_t            bcd_sts;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = PDATA_W'(buf_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RST;
    end else if (cfg_wr && (paddr[2] == REG_BUF_SIZE)) begin
      buf_size_r <= pwdata[BUF_W-1:0];
    end
  end

  // decode helpers
  assign expo      = bits_r[30:23];
  assign mant24    = {(expo != 8'd0), bits_r[22:0]};
  assign size_clip = (buf_size_r > MAXB) ? MAXB : buf_size_r;
  assign frac_zero = (x_r[FRAC_BITS-1:0] == '0);
  assign prod      = {1'b0, x_r[FRAC_BITS-1:0], 3'b000}
                   + {3'b000, x_r[FRAC_BITS-1:0], 1'b0};
  assign at_limit  = ((n_r + 1'b1) == limit_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    bits_nxt       = bits_r;
    x_nxt          = x_r;
    sh_nxt         = sh_r;
    n_nxt          = n_r;
    limit_nxt      = limit_r;
    dig_nxt        = dig_r;
    lead_nxt       = lead_r;
    neg_nxt        = neg_r;
    int_nz_nxt     = int_nz_r;
    emit           = 1'b0;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    bcd_ctl        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bits_nxt  = in_float_bits;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        limit_nxt = CW'(size_clip - 1'b1);
        n_nxt     = '0;
        neg_nxt   = bits_r[31];
        x_nxt     = {mant24, 7'd0, {FRAC_BITS{1'b0}}};
        sh_nxt    = (expo == 8'd0) ? SHIFT_SUB : SHIFT_BIAS - expo;
        if (buf_size_r == '0 || expo >= EXPO_OOR || size_clip == BUF_W'(1)) begin
          if (out_free) begin
            emit           = 1'b1;
            out_char_nxt   = CH_NUL;
            out_last_nxt   = 1'b1;
            out_status_nxt = (buf_size_r == '0) ? ST_NULL
                           : (expo >= EXPO_OOR) ? ST_RANGE : ST_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (sh_r == 8'd0) begin
          bcd_ctl.load = 1'b1;
          int_nz_nxt   = (x_r[XW-1:FRAC_BITS] != '0);
          neg_nxt      = neg_r && (x_r != '0);
          lead_nxt     = 1'b1;
          dig_nxt      = DCNT_W'(NDIG);
          state_nxt    = S_BCD;
        end else if (sh_r >= 8'd8) begin
          x_nxt  = x_r >> 8;
          sh_nxt = sh_r - 8'd8;
        end else begin
          x_nxt  = x_r >> 1;
          sh_nxt = sh_r - 8'd1;
        end
      end
      S_BCD: begin
        if (bcd_sts.done) begin
          state_nxt = neg_r ? S_SIGN : (int_nz_r ? S_INT : S_DOT);
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit           = 1'b1;
          out_char_nxt   = CH_MINUS;
          out_last_nxt   = at_limit;
          out_status_nxt = ST_OK;
          n_nxt          = n_r + 1'b1;
          state_nxt      = at_limit ? S_IDLE : (int_nz_r ? S_INT : S_DOT);
        end
      end
      S_INT: begin
        if (lead_r && bcd_sts.digit == 4'd0) begin
          // drop leading zero digits
          bcd_ctl.shift = 1'b1;
          dig_nxt       = dig_r - 1'b1;
        end else if (out_free) begin
          emit           = 1'b1;
          out_char_nxt   = CH_ZERO + {4'd0, bcd_sts.digit};
          out_last_nxt   = at_limit;
          out_status_nxt = ST_OK;
          n_nxt          = n_r + 1'b1;
          lead_nxt       = 1'b0;
          bcd_ctl.shift  = 1'b1;
          dig_nxt        = dig_r - 1'b1;
          if (at_limit) begin
            state_nxt = S_IDLE;
          end else if (dig_r == DCNT_W'(1)) begin
            state_nxt = S_DOT;
          end
        end
      end
      S_DOT: begin
        if (out_free) begin
          emit           = 1'b1;
          out_char_nxt   = CH_DOT;
          out_last_nxt   = at_limit || frac_zero;
          out_status_nxt = ST_OK;
          n_nxt          = n_r + 1'b1;
          state_nxt      = (at_limit || frac_zero) ? S_IDLE : S_FRAC;
        end
      end
      S_FRAC: begin
        // one decimal digit per multiply by ten
        if (out_free) begin
          emit                    = 1'b1;
          out_char_nxt            = CH_ZERO + {4'd0, prod[FRAC_BITS+3:FRAC_BITS]};
          out_last_nxt            = at_limit || (prod[FRAC_BITS-1:0] == '0);
          out_status_nxt          = ST_OK;
          n_nxt                   = n_r + 1'b1;
          x_nxt[FRAC_BITS-1:0]    = prod[FRAC_BITS-1:0];
          if (at_limit || (prod[FRAC_BITS-1:0] == '0)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r       <= bits_nxt;
    x_r          <= x_nxt;
    sh_r         <= sh_nxt;
    n_r          <= n_nxt;
    limit_r      <= limit_nxt;
    dig_r        <= dig_nxt;
    lead_r       <= lead_nxt;
    neg_r        <= neg_nxt;
    int_nz_r     <= int_nz_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;
  assign out_status    = out_status_r;

  // integer part to decimal
  f2da_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bcd_ctl),
    .bin   (x_r[XW-1:FRAC_BITS]),
    .sts   (bcd_sts)
  );

  // character count never reaches the limit while text is still due
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN || state_r == S_INT || state_r == S_DOT || state_r == S_FRAC)
    |-> (n_r < limit_r))
    else $error("character count past limit");

  // a flagged last character ends the item
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("sequencer busy after last character");

  // integer digits are only read once conversion is complete
  a_bcd_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT) |-> bcd_sts.done)
    else $error("digit read while BCD unit busy");

  // fraction stage runs only on a nonzero fraction
  a_frac_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRAC) |-> !frac_zero)
    else $error("fraction stage with zero fraction");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: regression bench for float_to_decimal_ascii
// Feeds raw single-precision patterns under several buffer sizes, predicts
// the decimal text character by character and checks every request on the
// result channel. Both channels see random gaps and stalls.
// ============================================================================
module tb;
  import f2da_pkg::*;

  localparam int MAX_BUF   = 64;
  localparam int LIMIT     = 1_200_000;
  localparam int MAX_SHOWN = 10;
  localparam logic [PADDR_W-1:0] ADDR_BUF_SIZE = {REG_BUF_SIZE, 2'b00};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
  } text_char_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [31:0]         in_float_bits = '0;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_text_char;
  logic                out_last_char;
  logic [1:0]          out_status;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [31:0]  float_q[$];   // patterns waiting to be driven
  text_char_t   text_q[$];    // characters still owed by the block
  logic [6:0]   buf_size_now; // predictor copy of buffer_size
  logic         in_fire = 1'b0;
  logic         no_idle;
  int           in_gap = 0;
  int           stall_left = 0;
  int           errors = 0;
  int           cycle_cnt = 0;

  float_to_decimal_ascii i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_float_bits (in_float_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // error log: first few in detail, the rest only counted
  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void owe_char(input logic [7:0] ch, input logic last,
                                   input logic [1:0] st);
    text_q.push_back('{ch: ch, last: last, st: st});
  endfunction

  // expected text of one pattern under the current buffer size
  function automatic void render_float(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [31:0] ipart;
    logic [63:0] frac;
    logic [63:0] rem;
    logic [67:0] prod;
    logic [7:0]  chars[$];
    logic [7:0]  idig[$];
    int          shift;
    int          room;
    expo = bits[30:23];
    mant = {1'b0, bits[22:0]};
    if (buf_size_now == 0) begin
      owe_char(CH_NUL, 1'b1, ST_NULL);
      return;
    end
    room = (buf_size_now > MAX_BUF) ? MAX_BUF - 1 : int'(buf_size_now) - 1;
    if (expo >= EXPO_OOR) begin
      owe_char(CH_NUL, 1'b1, ST_RANGE);
      return;
    end
    // magnitude = mant * 2^-shift
    if (expo == 0) begin
      shift = 149;
    end else begin
      mant[23] = 1'b1;
      shift = 150 - int'(expo);
    end
    if (shift <= 0) begin
      ipart = 32'(mant) << (-shift);
      frac  = '0;
    end else begin
      ipart = (shift < 32) ? (32'(mant) >> shift) : '0;
      rem   = (shift < 32) ? (64'(mant) & ((64'd1 << shift) - 1)) : 64'(mant);
      if (shift <= 64) frac = rem << (64 - shift);
      else if (shift - 64 < 64) frac = rem >> (shift - 64);
      else frac = '0;
    end
    // sign only for a nonzero magnitude
    if (bits[31] && (ipart != 0 || frac != 0) && chars.size() < room)
      chars.push_back(CH_MINUS);
    while (ipart > 0) begin
      idig.push_front(8'(CH_ZERO + ipart % 10));
      ipart = ipart / 10;
    end
    foreach (idig[i]) if (chars.size() < room) chars.push_back(idig[i]);
    if (chars.size() < room) chars.push_back(CH_DOT);
    // fraction digits by multiply-by-ten
    while (frac != 0 && chars.size() < room) begin
      prod = 68'(frac) * 68'd10;
      chars.push_back(8'(CH_ZERO + prod[67:64]));
      frac = prod[63:0];
    end
    if (chars.size() == 0) begin
      owe_char(CH_NUL, 1'b1, ST_OK);
      return;
    end
    foreach (chars[i]) owe_char(chars[i], i == chars.size() - 1, ST_OK);
  endfunction

  // random pattern, weighted toward values that convert to real text
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    int          r;
    r = $urandom_range(0, 9);
    f = $urandom;
    case (r)
      0, 1, 2, 3: f[30:23] = 8'($urandom_range(100, 157));
      4: f[30:23] = 8'($urandom_range(0, 30));
      5: f[30:23] = 8'($urandom_range(158, 255));
      6, 7: begin
        // few significant bits: short fractions
        f[30:23] = 8'($urandom_range(110, 157));
        f[22:0]  = f[22:0] & ~((23'd1 << $urandom_range(12, 23)) - 1);
      end
      8: begin
        // values of 1 and above with some low mantissa bits cleared
        f[30:23] = 8'($urandom_range(127, 157));
        f[22:0]  = f[22:0] & ~((23'd1 << $urandom_range(0, 23)) - 1);
      end
      default: ;
    endcase
    return f;
  endfunction

  // input driver: new request at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // held while stalled
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (float_q.size() > 0) begin
      in_valid      <= 1'b1;
      in_float_bits <= float_q.pop_front();
      in_gap        <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // monitor: predict on accepted input, check each accepted result
  always @(posedge clk) begin
    text_char_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) render_float(in_float_bits);
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0) begin
        flag_error($sformatf("unexpected char %02h last %0d status %0d",
                             out_text_char, out_last_char, out_status));
      end else begin
        want = text_q.pop_front();
        if (out_text_char !== want.ch)
          flag_error($sformatf("text_char exp %02h got %02h", want.ch, out_text_char));
        if (out_last_char !== want.last)
          flag_error($sformatf("last_char exp %0d got %0d", want.last, out_last_char));
        if (out_status !== want.st)
          flag_error($sformatf("status exp %0d got %0d", want.st, out_status));
      end
    end
  end

  // APB write of buffer_size, then read it back
  task automatic write_buf_size(input logic [6:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BUF_SIZE;
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    buf_size_now = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(val))
      flag_error($sformatf("buffer_size read exp %0d got %0d", val, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every request has gone through and the block is quiet;
  // checked at the rising edge, where the driver's updates have settled
  task automatic drain();
    while (float_q.size() != 0 || in_valid || text_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) float_q.push_back(rand_float());
  endtask

  // timeout
  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // sequence
  initial begin
    logic [31:0] directed[$];
    int          sz;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    buf_size_now  = BUF_SIZE_RST;
    no_idle       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zeros, signs, subnormals, range edges, inf, NaN, truncation at reset size
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h3F00_0000, 32'hBE80_0000, 32'h3DCC_CCCD, 32'h0000_0001,
                 32'h807F_FFFF, 32'h0080_0000, 32'h4EFF_FFFF, 32'hCEFF_FFFF,
                 32'h4F00_0000, 32'hCF00_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h42F6_E979,
                 32'h4B00_0001, 32'h3FFF_FFFF, 32'h447A_0000};
    foreach (directed[i]) float_q.push_back(directed[i]);
    drain();

    // null buffer, then a buffer with no room for any character
    write_buf_size(7'd0);
    float_q.push_back(32'h3F80_0000);
    float_q.push_back(32'h7FC0_0000);
    queue_random(3);
    drain();
    write_buf_size(7'd1);
    float_q.push_back(32'hC2F6_E979);
    float_q.push_back(32'hFF80_0000);
    queue_random(3);
    drain();

    // oversize register value clamps to the largest buffer
    write_buf_size(7'd127);
    float_q.push_back(32'h0000_0001);
    float_q.push_back(32'h3DCC_CCCD);
    queue_random(18);
    drain();

    // largest buffer, back to back with no idling
    no_idle = 1'b1;
    write_buf_size(7'd64);
    float_q.push_back(32'hCEFF_FFFF);
    queue_random(20);
    drain();
    no_idle = 1'b0;

    write_buf_size(7'd2);
    float_q.push_back(32'hBF80_0000);
    queue_random(5);
    drain();

    // random buffer sizes
    repeat (5) begin
      case ($urandom_range(0, 5))
        0: sz = $urandom_range(65, 127);
        1: sz = $urandom_range(0, 1);
        default: sz = $urandom_range(2, 24);
      endcase
      write_buf_size(7'(sz));
      queue_random(10);
      drain();
    end

    repeat (150) @(negedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
